[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file sts_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define STS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg
// Shared sizes and types of the sorted table swap-or-insert core.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;   // at most IN_W, the request field width

  localparam int IN_W  = 32;
  localparam int POS_W = 6;
  localparam int CNT_W = 7;

  localparam int TBL_AW = $clog2(TABLE_DEPTH);
  localparam int TBL_CW = $clog2(TABLE_DEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [TBL_AW-1:0]             tbl_addr_t;
  typedef logic [TBL_CW-1:0]             tbl_cnt_t;

  typedef struct packed {
    logic      we;
    tbl_addr_t waddr;
    val_t      wdata;
    logic      re;
    tbl_addr_t raddr;
  } mem_req_t;

endpackage

[rtl/sts_if.sv]
// ----------------------------------------------------------------------------
// sts_in_if / sts_out_if
// Valid/ready channels for lookup requests and their results.
// ----------------------------------------------------------------------------
interface sts_in_if import sts_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sts_out_if import sts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;
  logic             inserted;
  logic             overflow;
  logic [CNT_W-1:0] count;

  modport source (output valid, output found, output position, output inserted,
                  output overflow, output count, input ready);
  modport sink   (input valid, input found, input position, input inserted,
                  input overflow, input count, output ready);
endinterface

[rtl/sts_ram.sv]
// ----------------------------------------------------------------------------
// sts_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sts_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sts_ctrl.sv]
// ----------------------------------------------------------------------------
// sts_ctrl
// Sequencer: binary search, swap with successor, or shift-and-insert, all
// through one read port and one write port of the table RAM.
// ----------------------------------------------------------------------------
module sts_ctrl import sts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sts_in_if.sink    in_ch,
  sts_out_if.source out_ch,
  output mem_req_t  mem_req,
  input  val_t      mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SWAP_RD,
    S_SWAP_CMP,
    S_SWAP_WR,
    S_INS_RD,
    S_INS_CMP,
    S_INS_FIN,
    S_DONE
  } state_t;

  state_t    state_r;
  val_t      val_r;
  tbl_cnt_t  lo_r;
  tbl_cnt_t  hi1_r;      // upper bound, exclusive
  tbl_addr_t idx_r;
  tbl_cnt_t  cnt_r;

  logic      res_found_r;
  logic      res_ins_r;
  logic      res_ovf_r;
  tbl_addr_t res_pos_r;

  logic             out_valid_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_pos_r;
  logic             out_ins_r;
  logic             out_ovf_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic [TBL_CW:0] mid_sum;
  tbl_addr_t       mid;
  logic            rd_eq;
  logic            rd_gt;
  tbl_cnt_t        lo_nxt;
  tbl_cnt_t        hi1_nxt;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi1_r} - (TBL_CW + 1)'(1);
  assign mid     = TBL_AW'(mid_sum >> 1);
  assign rd_eq   = (mem_rdata == val_r);
  assign rd_gt   = (mem_rdata > val_r);
  assign lo_nxt  = rd_gt ? lo_r : (TBL_CW'(idx_r) + TBL_CW'(1));
  assign hi1_nxt = rd_gt ? TBL_CW'(idx_r) : hi1_r;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.inserted = out_ins_r;
  assign out_ch.overflow = out_ovf_r;
  assign out_ch.count    = out_cnt_r;

  // Memory port drive, decoded from the current state.
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = val_r;
    unique case (state_r)
      S_SRCH_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = mid;
      end
      S_SWAP_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_r + TBL_AW'(1);
      end
      S_SWAP_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = mem_rdata;
      end
      S_SWAP_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r + TBL_AW'(1);
      end
      S_INS_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_r;
      end
      S_INS_CMP: begin
        // Move the larger entry up one place, or drop the value in the gap.
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r + TBL_AW'(1);
        mem_req.wdata = rd_gt ? mem_rdata : val_r;
        mem_req.re    = rd_gt && (idx_r != '0);
        mem_req.raddr = idx_r - TBL_AW'(1);
      end
      S_INS_FIN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = '0;
      end
      S_IDLE, S_SRCH_CMP, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the taken result unless a new one loads this cycle.
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            val_r       <= val_t'(in_ch.value[VALUE_WIDTH-1:0]);
            lo_r        <= '0;
            hi1_r       <= cnt_r;
            res_found_r <= 1'b0;
            res_ins_r   <= 1'b0;
            res_ovf_r   <= 1'b0;
            res_pos_r   <= '0;
            priority if (cnt_r != '0) begin
              state_r <= S_SRCH_RD;
            end else begin
              state_r <= S_INS_FIN;
            end
          end
        end

        S_SRCH_RD: begin
          idx_r   <= mid;
          state_r <= S_SRCH_CMP;
        end

        S_SRCH_CMP: begin
          priority if (rd_eq) begin
            res_found_r <= 1'b1;
            res_pos_r   <= idx_r;
            if (TBL_CW'(idx_r) + TBL_CW'(1) < cnt_r) begin
              state_r <= S_SWAP_RD;
            end else begin
              state_r <= S_DONE;
            end
          end else if (lo_nxt < hi1_nxt) begin
            lo_r    <= lo_nxt;
            hi1_r   <= hi1_nxt;
            state_r <= S_SRCH_RD;
          end else if (cnt_r == TBL_CW'(TABLE_DEPTH)) begin
            res_ovf_r <= 1'b1;
            state_r   <= S_DONE;
          end else begin
            idx_r   <= TBL_AW'(cnt_r - TBL_CW'(1));
            state_r <= S_INS_RD;
          end
        end

        S_SWAP_RD: begin
          state_r <= S_SWAP_CMP;
        end

        S_SWAP_CMP: begin
          state_r <= S_SWAP_WR;
        end

        S_SWAP_WR: begin
          state_r <= S_DONE;
        end

        S_INS_RD: begin
          state_r <= S_INS_CMP;
        end

        S_INS_CMP: begin
          priority if (!rd_gt) begin
            res_pos_r <= idx_r + TBL_AW'(1);
            res_ins_r <= 1'b1;
            cnt_r     <= cnt_r + TBL_CW'(1);
            state_r   <= S_DONE;
          end else if (idx_r == '0) begin
            state_r <= S_INS_FIN;
          end else begin
            idx_r <= idx_r - TBL_AW'(1);
          end
        end

        S_INS_FIN: begin
          res_pos_r <= '0;
          res_ins_r <= 1'b1;
          cnt_r     <= cnt_r + TBL_CW'(1);
          state_r   <= S_DONE;
        end

        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            out_pos_r   <= POS_W'(res_pos_r);
            out_ins_r   <= res_ins_r;
            out_ovf_r   <= res_ovf_r;
            out_cnt_r   <= CNT_W'(cnt_r);
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/sorted_table_swap_or_insert_core.sv]
// ----------------------------------------------------------------------------
// sorted_table_swap_or_insert_core
// Sorted table of signed values with lookup, swap-with-successor and insert.
// ----------------------------------------------------------------------------
// The table starts empty after reset and holds up to 64 entries in a RAM with
// one read and one write port. One request is processed at a time: a binary
// search reads and compares one probe per pass (S_SRCH_RD, S_SRCH_CMP), a
// swap reads the successor and writes the pair back (S_SWAP_RD to S_SWAP_WR),
// and an insert shifts each larger entry up one place (S_INS_RD, S_INS_CMP).
// A result sits in an output register while the next request is taken; a
// value that is absent from a full table is dropped with overflow.
// ----------------------------------------------------------------------------
module sorted_table_swap_or_insert_core import sts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sts_in_if.sink    in_ch,
  sts_out_if.source out_ch
);

  mem_req_t mem_req;
  val_t     mem_rdata;

  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  sts_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

[rtl/sts_checker.sv]
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks of the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sts_checker import sts_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_found,
  input logic [POS_W-1:0] out_position,
  input logic             out_inserted,
  input logic             out_overflow,
  input logic [CNT_W-1:0] out_count
);

  `STS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_found, out_position, out_inserted, out_overflow, out_count}), "stalled result changed")
  `STS_ASSERT_NOW(a_one_outcome, clk, rst_n, out_valid, $onehot({out_found, out_inserted, out_overflow}), "result must be exactly one of found, inserted, overflow")
  `STS_ASSERT_NOW(a_ovf_full, clk, rst_n, out_valid && out_overflow, (out_count == CNT_W'(TABLE_DEPTH)) && (out_position == '0), "overflow without full table")
  `STS_ASSERT_NOW(a_pos_in_range, clk, rst_n, out_valid && (out_found || out_inserted), CNT_W'(out_position) < out_count, "position beyond entry count")

endmodule

bind sorted_table_swap_or_insert_core sts_checker u_sts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_found    (out_ch.found),
  .out_position (out_ch.position),
  .out_inserted (out_ch.inserted),
  .out_overflow (out_ch.overflow),
  .out_count    (out_ch.count)
);
